FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while the active-low reset is asserted.
`define CHK_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Clocked next-cycle implication.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gbkf_pkg.sv
// ----------------------------------------------------------------------------
// gbkf_pkg
// Types, constants and helpers shared by the gyro bias Kalman filter.
// ----------------------------------------------------------------------------
package gbkf_pkg;

    localparam int unsigned NUM_AXES_DEF = 3;
    localparam logic signed [31:0] COV_INIT = 32'sd1677722;
    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    // Register indexes.
    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_RNOISE  = 3'd1;
    localparam logic [2:0] REG_QANGLE  = 3'd2;
    localparam logic [2:0] REG_QCROSSA = 3'd3;
    localparam logic [2:0] REG_QCROSSB = 3'd4;
    localparam logic [2:0] REG_QBIAS   = 3'd5;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
    } gbkf_in_t;

    typedef struct packed {
        logic [1:0]         axis_out;
        logic signed [31:0] fused_angle;
        logic signed [31:0] corrected_rate;
    } gbkf_out_t;

    // Divider control and status.
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } gbkf_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } gbkf_div_rsp_t;

    // Saturate a 34-bit sum to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat34(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat34(34'(a) - 34'(b));
    endfunction

endpackage

FILE: rtl/gbkf_mul.sv
// ----------------------------------------------------------------------------
// gbkf_mul
// Shared rounding multiplier: registered 33x32 product, then round-to-nearest
// (ties up), shift by 16 or 24, saturate to 32 bits.
// ----------------------------------------------------------------------------
module gbkf_mul
    import gbkf_pkg::*;
(
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [31:0] op_b,
    input  logic               shift24,
    output logic signed [31:0] result
);

    logic signed [64:0] prod_reg;
    logic               sh_reg;
    logic signed [64:0] rnd;
    logic signed [64:0] shv;

    // Product register stage.
    always_ff @(posedge aclk) begin
        prod_reg <= 65'(op_a) * 65'(op_b);
        sh_reg   <= shift24;
    end

    // Round, arithmetic shift (floor), saturate.
    always_comb begin
        if (sh_reg) begin
            rnd = prod_reg + (65'sd1 <<< 23);
            shv = rnd >>> 24;
        end else begin
            rnd = prod_reg + (65'sd1 <<< 15);
            shv = rnd >>> 16;
        end
        if (shv > 65'sd2147483647) begin
            result = 32'sh7FFFFFFF;
        end else if (shv < -65'sd2147483648) begin
            result = 32'sh80000000;
        end else begin
            result = shv[31:0];
        end
    end

endmodule

FILE: rtl/gbkf_div.sv
// ----------------------------------------------------------------------------
// gbkf_div
// Restoring divider, one quotient bit a cycle: (num * 2^24) / den truncated
// toward zero and saturated; zero when den is not positive.
// ----------------------------------------------------------------------------
module gbkf_div
    import gbkf_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  gbkf_div_req_t req,
    output gbkf_div_rsp_t rsp
);

    localparam int unsigned NBITS = 56;

    logic [55:0] dvd_reg, dvd_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] num_mag;
    logic signed [57:0] sq;

    assign num_mag = req.num[31] ? 32'(-req.num) : req.num;
    assign trial   = {rem_reg, dvd_reg[55]} - {2'b0, den_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = {num_mag, 24'd0};
            rem_next  = '0;
            den_next  = req.den[30:0];
            neg_next  = req.num[31];
            zero_next = (req.den <= 0);
            cnt_next  = 6'(NBITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // One shift-subtract step.
            if (!trial[32]) begin
                rem_next = trial[31:0];
            end else begin
                rem_next = {rem_reg[30:0], dvd_reg[55]};
            end
            dvd_next = {dvd_reg[54:0], ~trial[32]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // Apply sign, saturate.
    always_comb begin
        sq = neg_reg ? -58'(dvd_reg) : 58'(dvd_reg);
        rsp.done = done_reg;
        if (zero_reg) begin
            rsp.quo = '0;
        end else if (sq > 58'sd2147483647) begin
            rsp.quo = 32'sh7FFFFFFF;
        end else if (sq < -58'sd2147483648) begin
            rsp.quo = 32'sh80000000;
        end else begin
            rsp.quo = sq[31:0];
        end
    end

endmodule

FILE: rtl/gyro_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// gyro_bias_kalman_filter
// Per-axis two-state Kalman filter for angle and gyro bias.
// ----------------------------------------------------------------------------
// Each beat on the input channel names an axis and brings a measured angle
// and a gyro rate; exactly one result beat follows. The block handles one
// beat at a time: a sequencer runs eleven products through one shared
// registered multiplier and two gains through a one-bit-a-cycle divider,
// and the next input beat can be taken in the cycle after the result beat
// is taken. An axis of NUM_AXES or above leaves all state alone and returns
// zero angle and rate on the next cycle. Registers must be written over the
// APB port only while the block is idle; the block itself does not enforce
// this.
module gyro_bias_kalman_filter
    import gbkf_pkg::*;
#(
    parameter int unsigned NUM_AXES = NUM_AXES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  gbkf_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output gbkf_out_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV0 = 3'd2;
    localparam logic [2:0] ST_DIV1 = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // Configuration registers.
    logic [16:0]        period_reg;
    logic [30:0]        rnoise_reg;
    logic [30:0]        qangle_reg;
    logic signed [31:0] qcra_reg;
    logic signed [31:0] qcrb_reg;
    logic [30:0]        qbias_reg;
    logic [2:0]         ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= 17'd262;
            rnoise_reg <= 31'd503316;
            qangle_reg <= 31'd16777;
            qcra_reg   <= '0;
            qcrb_reg   <= '0;
            qbias_reg  <= 31'd16777;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_PERIOD:  period_reg <= pwdata[16:0];
                REG_RNOISE:  rnoise_reg <= pwdata[30:0];
                REG_QANGLE:  qangle_reg <= pwdata[30:0];
                REG_QCROSSA: qcra_reg   <= pwdata;
                REG_QCROSSB: qcrb_reg   <= pwdata;
                REG_QBIAS:   qbias_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_PERIOD:  prdata = {15'd0, period_reg};
            REG_RNOISE:  prdata = {1'b0, rnoise_reg};
            REG_QANGLE:  prdata = {1'b0, qangle_reg};
            REG_QCROSSA: prdata = qcra_reg;
            REG_QCROSSB: prdata = qcrb_reg;
            REG_QBIAS:   prdata = {1'b0, qbias_reg};
            default:     prdata = '0;
        endcase
    end

    // Per-axis state (small register arrays, read at the latched axis).
    logic signed [31:0] ang_reg [NUM_AXES];
    logic signed [31:0] bias_reg [NUM_AXES];
    logic signed [31:0] intg_reg [NUM_AXES];
    logic signed [31:0] c00_reg [NUM_AXES];
    logic signed [31:0] c01_reg [NUM_AXES];
    logic signed [31:0] c10_reg [NUM_AXES];
    logic signed [31:0] c11_reg [NUM_AXES];

    // Working registers.
    logic [2:0]         st_reg;
    logic [4:0]         step_reg;
    logic               ph_reg;
    logic [1:0]         axin_reg;
    logic [AW-1:0]      ax_reg;
    logic signed [31:0] y_reg, u_reg;
    logic signed [31:0] a00, a01, p00, p01, p10, p11, k0, k1, ah, wb, rt, tmp, svar;
    logic               ovalid_reg;
    gbkf_out_t          odata_reg;

    // Shared multiplier operands.
    logic signed [32:0] ma;
    logic signed [31:0] mb;
    logic               msh;
    logic signed [31:0] mres;

    gbkf_mul u_mul (
        .aclk    (aclk),
        .op_a    (ma),
        .op_b    (mb),
        .shift24 (msh),
        .result  (mres)
    );

    gbkf_div_req_t dreq;
    gbkf_div_rsp_t drsp;

    gbkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    logic signed [32:0] dt33;
    assign dt33 = {16'd0, period_reg};

    // Operand select per multiply step.
    always_comb begin
        ma  = dt33;
        mb  = '0;
        msh = 1'b0;
        case (step_reg)
            5'd0: mb = c10_reg[ax_reg];
            5'd1: mb = c11_reg[ax_reg];
            5'd2: mb = a01;
            5'd3: mb = rt;
            5'd4: begin ma = 33'(k1); mb = tmp; msh = 1'b1; end
            5'd5: begin ma = 33'(k0); mb = tmp; msh = 1'b1; end
            5'd6: begin ma = 33'(tmp); mb = p00; msh = 1'b1; end
            5'd7: begin ma = 33'(tmp); mb = p01; msh = 1'b1; end
            5'd8: begin ma = 33'(k1); mb = p00; msh = 1'b1; end
            5'd9: begin ma = 33'(k1); mb = p01; msh = 1'b1; end
            5'd10: mb = rt;
            default: ;
        endcase
    end

    assign s_ready = (st_reg == ST_IDLE) && !ovalid_reg;
    assign m_valid = ovalid_reg;
    assign m_data  = odata_reg;

    // Both gains divide by the innovation variance held in svar.
    always_comb begin
        dreq.start = 1'b0;
        dreq.num   = p00;
        dreq.den   = svar;
        if (st_reg == ST_MUL && ph_reg && step_reg == 5'd3) begin
            dreq.start = 1'b1;
        end else if (st_reg == ST_DIV0 && drsp.done) begin
            dreq.start = 1'b1;
            dreq.num   = p10;
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            step_reg   <= '0;
            ph_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                ang_reg[i]  <= '0;
                bias_reg[i] <= '0;
                intg_reg[i] <= '0;
                c00_reg[i]  <= COV_INIT;
                c01_reg[i]  <= '0;
                c10_reg[i]  <= '0;
                c11_reg[i]  <= COV_INIT;
            end
        end else begin
            if (m_valid && m_ready) begin
                ovalid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        axin_reg <= s_data.axis;
                        ax_reg   <= AW'(s_data.axis);
                        y_reg    <= s_data.measured_angle;
                        u_reg    <= s_data.gyro_rate;
                        step_reg <= '0;
                        ph_reg   <= 1'b0;
                        if (32'(s_data.axis) >= NUM_AXES) begin
                            odata_reg  <= '{axis_out: s_data.axis,
                                           fused_angle: '0, corrected_rate: '0};
                            ovalid_reg <= 1'b1;
                        end else begin
                            st_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        step_reg <= step_reg + 5'd1;
                        case (step_reg)
                            5'd0: a00 <= sub_sat(c00_reg[ax_reg], mres);
                            5'd1: begin
                                a01 <= sub_sat(c01_reg[ax_reg], mres);
                                p10 <= add_sat(sub_sat(c10_reg[ax_reg], mres), qcrb_reg);
                                p11 <= add_sat(c11_reg[ax_reg], 32'(qbias_reg));
                            end
                            5'd2: begin
                                p00  <= add_sat(sub_sat(a00, mres), 32'(qangle_reg));
                                p01  <= add_sat(a01, qcra_reg);
                                svar <= add_sat(add_sat(sub_sat(a00, mres),
                                                32'(qangle_reg)), 32'(rnoise_reg));
                                // Rate with the old bias, ready for the next product.
                                rt   <= sub_sat(u_reg, bias_reg[ax_reg]);
                            end
                            5'd3: begin
                                ah  <= add_sat(ang_reg[ax_reg], mres);
                                tmp <= sub_sat(y_reg, add_sat(ang_reg[ax_reg], mres));
                                wb  <= bias_reg[ax_reg];
                                st_reg <= ST_DIV0;
                            end
                            5'd4: wb <= add_sat(wb, mres);
                            5'd5: begin
                                ah  <= add_sat(ah, mres);
                                tmp <= sub_sat(ONE_Q24, k0);
                            end
                            5'd6: c00_reg[ax_reg] <= mres;
                            5'd7: c01_reg[ax_reg] <= mres;
                            5'd8: c10_reg[ax_reg] <= sub_sat(p10, mres);
                            5'd9: begin
                                c11_reg[ax_reg] <= sub_sat(p11, mres);
                                rt <= sub_sat(u_reg, wb);
                            end
                            default: begin
                                intg_reg[ax_reg] <= add_sat(intg_reg[ax_reg], mres);
                                bias_reg[ax_reg] <= wb;
                                ang_reg[ax_reg]  <= ah;
                                odata_reg <= '{axis_out: axin_reg,
                                               fused_angle: add_sat(intg_reg[ax_reg], mres),
                                               corrected_rate: rt};
                                st_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_DIV0: begin
                    if (drsp.done) begin
                        k0     <= drsp.quo;
                        st_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (drsp.done) begin
                        k1     <= drsp.quo;
                        st_reg <= ST_MUL;
                        ph_reg <= 1'b0;
                    end
                end
                ST_OUT: begin
                    ovalid_reg <= 1'b1;
                    st_reg     <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/gbkf_checker.sv
// ----------------------------------------------------------------------------
// gbkf_checker
// Port-level checks of the filter's handshakes and register port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbkf_checker
    import gbkf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input gbkf_out_t m_data,
    input logic      pready
);

    // A beat accepted on the input means no input is taken next cycle.
    `CHK_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken twice")
    // While a result waits, no new item is taken.
    `CHK_IMPLY(a_no_take_while_out, aclk, aresetn, m_valid, !s_ready, "input taken during output")
    // A stalled result holds.
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed")
    // Register port never stalls.
    `CHK_IMPLY(a_pready, aclk, aresetn, 1'b1, pready, "pready low")

endmodule

bind gyro_bias_kalman_filter gbkf_checker u_gbkf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

FILE: sim/gyro_bias_kalman_filter_tb.sv
// ----------------------------------------------------------------------------
// gyro_bias_kalman_filter_tb
// Self-checking testbench for the per-axis angle and gyro bias Kalman filter.
// ----------------------------------------------------------------------------
// A short table of directed beats is sent first. It covers every axis, an
// axis beyond the filter count, and the extremes of the measured angle and
// the gyro rate. Random beats follow in phases with different register
// settings, extremes included. A fixed-point model inside the bench tracks
// the filter state per axis. Each result beat is checked field by field
// against the oldest predicted result. Both channels idle at random, except in the last two phases.
module gyro_bias_kalman_filter_tb;
    import gbkf_pkg::*;

    localparam int unsigned AXES = NUM_AXES_DEF;
    localparam int unsigned RUN_LIMIT = 2000000;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned NUM_PHASES = 6;
    // An index past the last register, which the block must ignore.
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct {
        gbkf_in_t  item;
        bit        fixed_want;
        gbkf_out_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    gbkf_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    gbkf_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Filter state and register copies kept by the bench.
    longint             dt_q16;
    longint             r_noise;
    longint             q_angle;
    logic signed [31:0] q_cross_a;
    logic signed [31:0] q_cross_b;
    longint             q_bias;
    logic signed [31:0] est_angle [AXES];
    logic signed [31:0] est_bias  [AXES];
    logic signed [31:0] out_angle [AXES];
    logic signed [31:0] p00 [AXES];
    logic signed [31:0] p01 [AXES];
    logic signed [31:0] p10 [AXES];
    logic signed [31:0] p11 [AXES];

    gbkf_out_t   pending_results [$];
    dir_row_t    directed_rows [$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned cycle_count;

    gyro_bias_kalman_filter uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // Hard limit on the run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Product rounded to nearest with ties toward plus infinity, then shifted.
    function automatic logic signed [31:0] mul_round(input longint a, input longint b,
                                                     input int unsigned sh);
        longint p;
        p = a * b + (64'sd1 <<< (sh - 1));
        return clamp32(p >>> sh);
    endfunction

    function automatic logic signed [31:0] kalman_gain(input logic signed [31:0] num,
                                                       input logic signed [31:0] den);
        longint n;
        longint d;
        if (den <= 0) begin
            return 32'sd0;
        end
        n = num;
        d = den;
        return clamp32((n * 64'sd16777216) / d);
    endfunction

    task automatic reset_model();
        dt_q16 = 262;
        r_noise = 503316;
        q_angle = 16777;
        q_cross_a = 0;
        q_cross_b = 0;
        q_bias = 16777;
        for (int i = 0; i < AXES; i++) begin
            est_angle[i] = 0;
            est_bias[i] = 0;
            out_angle[i] = 0;
            p00[i] = COV_INIT;
            p01[i] = 0;
            p10[i] = 0;
            p11[i] = COV_INIT;
        end
    endtask

    // One filter step on the bench copy of the state.
    function automatic gbkf_out_t filter_step(input gbkf_in_t x);
        gbkf_out_t r;
        int unsigned a;
        logic signed [31:0] ap00, ap01, pp00, pp01, pp10, pp11, s, k0, k1, omk0;
        logic signed [31:0] rate, ah, innov, wb;
        longint y, u;
        r.axis_out = x.axis;
        r.fused_angle = 0;
        r.corrected_rate = 0;
        if (x.axis >= AXES) begin
            return r;
        end
        a = x.axis;
        y = x.measured_angle;
        u = x.gyro_rate;

        // Covariance prediction.
        ap00 = clamp32(longint'(p00[a]) - mul_round(dt_q16, p10[a], 16));
        ap01 = clamp32(longint'(p01[a]) - mul_round(dt_q16, p11[a], 16));
        pp00 = clamp32(longint'(clamp32(longint'(ap00) - mul_round(dt_q16, ap01, 16)))
                       + q_angle);
        pp01 = clamp32(longint'(ap01) + longint'(q_cross_a));
        pp10 = clamp32(longint'(clamp32(longint'(p10[a]) - mul_round(dt_q16, p11[a], 16)))
                       + longint'(q_cross_b));
        pp11 = clamp32(longint'(p11[a]) + q_bias);

        // Innovation variance and gains.
        s = clamp32(longint'(pp00) + r_noise);
        k0 = kalman_gain(pp00, s);
        k1 = kalman_gain(pp10, s);

        // Estimate correction.
        wb = est_bias[a];
        rate = clamp32(u - longint'(wb));
        ah = clamp32(longint'(est_angle[a]) + mul_round(dt_q16, rate, 16));
        innov = clamp32(y - longint'(ah));
        wb = clamp32(longint'(wb) + mul_round(k1, innov, 24));
        ah = clamp32(longint'(ah) + mul_round(k0, innov, 24));
        est_bias[a] = wb;
        est_angle[a] = ah;

        // Covariance update.
        omk0 = clamp32(64'sd16777216 - longint'(k0));
        p00[a] = mul_round(omk0, pp00, 24);
        p01[a] = mul_round(omk0, pp01, 24);
        p10[a] = clamp32(longint'(pp10) - mul_round(k1, pp00, 24));
        p11[a] = clamp32(longint'(pp11) - mul_round(k1, pp01, 24));

        // Output angle integrates the rate corrected by the new bias.
        rate = clamp32(u - longint'(wb));
        out_angle[a] = clamp32(longint'(out_angle[a]) + mul_round(dt_q16, rate, 16));
        r.fused_angle = out_angle[a];
        r.corrected_rate = rate;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // APB register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_PERIOD:  dt_q16 = value & 32'h1FFFF;
            REG_RNOISE:  r_noise = value & 32'h7FFFFFFF;
            REG_QANGLE:  q_angle = value & 32'h7FFFFFFF;
            REG_QCROSSA: q_cross_a = value;
            REG_QCROSSB: q_cross_b = value;
            REG_QBIAS:   q_bias = value & 32'h7FFFFFFF;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] period, input logic [31:0] rn,
                                  input logic [31:0] qa, input logic [31:0] ca,
                                  input logic [31:0] cb, input logic [31:0] qb);
        write_reg(REG_PERIOD, period);
        write_reg(REG_RNOISE, rn);
        write_reg(REG_QANGLE, qa);
        write_reg(REG_QCROSSA, ca);
        write_reg(REG_QCROSSB, cb);
        write_reg(REG_QBIAS, qb);
    endtask

    // Presents one beat; the predicted result is queued once it is taken.
    task automatic send_beat(input gbkf_in_t x, input bit fixed_want, input gbkf_out_t want);
        gbkf_out_t predicted;
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        predicted = filter_step(x);
        pending_results.push_back(fixed_want ? want : predicted);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_signal();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
        end else if (pick < 85) begin
            return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
        end
        return $urandom;
    endfunction

    function automatic gbkf_in_t random_beat();
        gbkf_in_t x;
        x.axis = ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(AXES - 1));
        x.measured_angle = random_signal();
        x.gyro_rate = random_signal();
        return x;
    endfunction

    task automatic add_row(input logic [1:0] ax, input logic [31:0] y, input logic [31:0] u,
                           input bit fixed_want, input logic [31:0] fa, input logic [31:0] cr);
        dir_row_t row;
        row.item = '{axis: ax, measured_angle: y, gyro_rate: u};
        row.fixed_want = fixed_want;
        row.want = '{axis_out: ax, fused_angle: fa, corrected_rate: cr};
        directed_rows.push_back(row);
    endtask

    // Result channel: check each beat taken, stall at random.
    initial begin
        gbkf_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", m_data.fused_angle, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.axis_out != want.axis_out) begin
                        report_mismatch("axis_out", 32'(m_data.axis_out),
                                        32'(want.axis_out));
                    end
                    if (m_data.fused_angle != want.fused_angle) begin
                        report_mismatch("fused_angle", m_data.fused_angle, want.fused_angle);
                    end
                    if (m_data.corrected_rate != want.corrected_rate) begin
                        report_mismatch("corrected_rate", m_data.corrected_rate,
                                        want.corrected_rate);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        mismatches = 0;
        send_idle_pct = 35;
        recv_idle_pct = 67;
        reset_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: zero state gives zero outputs, unused axis gives zeros.
        add_row(2'd0, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0);
        add_row(2'd1, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0);
        add_row(2'd2, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0);
        add_row(2'd3, 32'h7FFFFFFF, 32'h80000000, 1'b1, 32'd0, 32'd0);
        add_row(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0);
        for (int a = 0; a < AXES; a++) begin
            add_row(2'(a), 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'd0, 32'd0);
            add_row(2'(a), 32'h80000000, 32'h80000000, 1'b0, 32'd0, 32'd0);
            add_row(2'(a), 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'd0, 32'd0);
            add_row(2'(a), 32'h00010000, 32'hFFFF0000, 1'b0, 32'd0, 32'd0);
            add_row(2'(a), 32'h7FFFFFFF, 32'h80000000, 1'b0, 32'd0, 32'd0);
        end
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].item, directed_rows[i].fixed_want,
                      directed_rows[i].want);
        end
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_all_regs(32'd65536, 32'd1, 32'd0, 32'h7FFFFFFF, 32'h80000000, 32'd0);
                1: write_all_regs(32'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                  32'h7FFFFFFF, 32'h7FFFFFFF);
                2: write_all_regs(32'd262, 32'd503316, 32'd16777, 32'd0, 32'd0, 32'd16777);
                3: write_all_regs(32'hFFFFFFFF, 32'd0, $urandom, $urandom, $urandom, $urandom);
                default: write_all_regs($urandom_range(65536, 1), $urandom_range(1 << 26, 1),
                                        $urandom_range(1 << 22), $urandom, $urandom,
                                        $urandom_range(1 << 22));
            endcase
            write_reg(REG_UNUSED, $urandom);
            case (ph / 2)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 67;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_beat(random_beat(), 1'b0, '0);
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
